### rtl/srrp_pkg.sv
// ----------------------------------------------------------------------------
// srrp_pkg - shared definitions for the storage row record parser
// Phase encoding, result kinds, error codes, mask bits and port widths.
// ----------------------------------------------------------------------------
`default_nettype none

package srrp_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 176;   // 171 payload bits padded to whole bytes
    localparam int KIND_W      = 4;
    localparam int ERR_W       = 3;
    localparam int FCNT_W      = 4;     // counts up to the 12 deletion bytes
    localparam int LEN_W       = 32;

    typedef enum logic [3:0] {
        PH_ROW_LEN   = 4'd0,
        PH_KEY       = 4'd1,
        PH_ROW_DEL   = 4'd2,
        PH_ATOM_LEN  = 4'd3,
        PH_NAME      = 4'd4,
        PH_MASK      = 4'd5,
        PH_EXP       = 4'd6,
        PH_TS        = 4'd7,
        PH_VLEN      = 4'd8,
        PH_VALUE     = 4'd9,
        PH_DEL_VALUE = 4'd10,
        PH_RT_LEN    = 4'd11,
        PH_RT_NAME   = 4'd12,
        PH_RT_DEL    = 4'd13
    } t_phase;

    localparam logic [KIND_W-1:0] K_KEY_BYTE   = 4'd0;
    localparam logic [KIND_W-1:0] K_ROW_START  = 4'd1;
    localparam logic [KIND_W-1:0] K_NAME_BYTE  = 4'd2;
    localparam logic [KIND_W-1:0] K_VALUE_BYTE = 4'd3;
    localparam logic [KIND_W-1:0] K_CELL       = 4'd4;
    localparam logic [KIND_W-1:0] K_DEL_CELL   = 4'd5;
    localparam logic [KIND_W-1:0] K_END_NAME   = 4'd6;
    localparam logic [KIND_W-1:0] K_TOMBSTONE  = 4'd7;
    localparam logic [KIND_W-1:0] K_ROW_END    = 4'd8;
    localparam logic [KIND_W-1:0] K_STREAM_END = 4'd9;
    localparam logic [KIND_W-1:0] K_ERROR      = 4'd10;

    localparam logic [ERR_W-1:0] E_NONE        = 3'd0;
    localparam logic [ERR_W-1:0] E_COUNTER     = 3'd1;
    localparam logic [ERR_W-1:0] E_COUNTER_UPD = 3'd2;
    localparam logic [ERR_W-1:0] E_DEL_SIZE    = 3'd3;
    localparam logic [ERR_W-1:0] E_TRUNCATED   = 3'd4;

    localparam int M_DELETION       = 0;
    localparam int M_EXPIRATION     = 1;
    localparam int M_COUNTER        = 2;
    localparam int M_COUNTER_UPDATE = 3;
    localparam int M_RANGE_TOMB     = 4;

endpackage

`default_nettype wire

### rtl/storage_row_record_parser.sv
// ----------------------------------------------------------------------------
// storage_row_record_parser - byte-serial parser for big-endian row records
// Splits a row stream into tagged key/name/value bytes and row/cell events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one stream byte per transaction on s_tdata; s_tlast
//   high marks an end-of-input transaction whose byte is ignored.
//   Master channel (m_*): at most one result transaction per input byte.
//   m_tuser carries the result kind, m_tlast flags the final byte of a field,
//   m_tdata carries the byte, deletion time, timestamp, ttl, expiration and
//   error code.
//   Timing: a byte taken into the input register is parsed by the parse stage
//   and its result is registered in the result register; while that register
//   holds an untaken transaction the byte waits in the input register.
//   Throughput: one byte per cycle while the result register is free, set by
//   the single parse stage between the input register and the result register.
//   Stalls: while the result register holds an untaken transaction, the parse
//   stage holds and the input register fills; s_tready drops once both are
//   full. Nothing is lost or repeated.
//   Reset: the parser returns to the start of a row with no error held; both
//   registers empty. Errors are sticky until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module storage_row_record_parser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [srrp_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
    input  wire logic                             s_tlast,   // end_of_input
    // master side
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] data_byte, [39:8] del_time, [103:40] timestamp,
    // [135:104] ttl, [167:136] expiration, [170:168] error_code, rest zero
    output logic [srrp_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tlast,   // last_byte
    output logic [srrp_pkg::KIND_W-1:0]           m_tuser    // [3:0] kind
);
    import srrp_pkg::*;

    // input register
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_end;

    // parser state
    t_phase                r_phase,    n_phase;
    logic [FCNT_W-1:0]     r_fcnt,     n_fcnt;
    logic [LEN_W-1:0]      r_len,      n_len;
    logic [31:0]           r_dtime,    n_dtime;
    logic [63:0]           r_tstamp,   n_tstamp;
    logic [31:0]           r_ttl,      n_ttl;
    logic [31:0]           r_exp,      n_exp;
    logic                  r_cell_del, n_cell_del;
    logic [ERR_W-1:0]      r_err,      n_err;

    // result register
    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_out_kind;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;
    logic [31:0]           r_out_dtime;
    logic [63:0]           r_out_tstamp;
    logic [31:0]           r_out_ttl;
    logic [31:0]           r_out_exp;
    logic [ERR_W-1:0]      r_out_err;

    // parse stage result
    logic                  res_valid;
    logic [KIND_W-1:0]     res_kind;
    logic [7:0]            res_byte;
    logic                  res_last;
    logic [31:0]           res_dtime;
    logic [63:0]           res_tstamp;
    logic [31:0]           res_ttl;
    logic [31:0]           res_exp;
    logic [ERR_W-1:0]      res_err;

    logic                  out_free;
    logic                  consume;
    logic [7:0]            b;
    logic [FCNT_W-1:0]     fcnt_inc;
    logic [LEN_W-1:0]      len_shift;
    logic [LEN_W-1:0]      len_dec;

    // advance the parse stage whenever the result register can take its output
    assign out_free = !r_out_valid || m_tready;
    assign consume  = r_in_valid && out_free;
    assign s_tready = !r_in_valid || consume;

    assign b         = r_in_byte;
    assign fcnt_inc  = r_fcnt + 1'b1;
    // first byte of a length clears the upper bits, later bytes shift in
    assign len_shift = (r_fcnt == '0) ? {{(LEN_W-8){1'b0}}, b} : {r_len[LEN_W-9:0], b};
    assign len_dec   = r_len - 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_fcnt     = r_fcnt;
        n_len      = r_len;
        n_dtime    = r_dtime;
        n_tstamp   = r_tstamp;
        n_ttl      = r_ttl;
        n_exp      = r_exp;
        n_cell_del = r_cell_del;
        n_err      = r_err;

        res_valid  = 1'b0;
        res_kind   = K_KEY_BYTE;
        res_byte   = '0;
        res_last   = 1'b0;
        res_dtime  = '0;
        res_tstamp = '0;
        res_ttl    = '0;
        res_exp    = '0;
        res_err    = E_NONE;

        if (r_in_end) begin
            res_valid = 1'b1;
            if (r_err != E_NONE) begin
                res_kind = K_ERROR;
                res_err  = r_err;
            end else if (r_phase == PH_ROW_LEN && r_fcnt == '0) begin
                res_kind = K_STREAM_END;
            end else begin
                res_kind = K_ERROR;
                res_err  = E_TRUNCATED;
                n_err    = E_TRUNCATED;
            end
        end else if (r_err == E_NONE) begin
            case (r_phase)
                PH_ROW_LEN, PH_ATOM_LEN, PH_RT_LEN: begin
                    n_len  = len_shift;
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= FCNT_W'(2)) begin
                        n_fcnt = '0;
                        if (r_phase == PH_ROW_LEN) begin
                            n_phase = (len_shift == '0) ? PH_ROW_DEL : PH_KEY;
                        end else if (r_phase == PH_RT_LEN) begin
                            n_phase = (len_shift == '0) ? PH_RT_DEL : PH_RT_NAME;
                        end else if (len_shift == '0) begin
                            n_phase   = PH_ROW_LEN;
                            res_valid = 1'b1;
                            res_kind  = K_ROW_END;
                        end else begin
                            n_phase = PH_NAME;
                        end
                    end
                end
                PH_KEY, PH_NAME, PH_VALUE, PH_RT_NAME: begin
                    n_len     = len_dec;
                    res_valid = 1'b1;
                    res_byte  = b;
                    case (r_phase)
                        PH_KEY:   res_kind = K_KEY_BYTE;
                        PH_NAME:  res_kind = K_NAME_BYTE;
                        PH_VALUE: res_kind = K_VALUE_BYTE;
                        default:  res_kind = K_END_NAME;
                    endcase
                    if (len_dec == '0) begin
                        res_last = 1'b1;
                        n_fcnt   = '0;
                        case (r_phase)
                            PH_KEY:   n_phase = PH_ROW_DEL;
                            PH_NAME:  n_phase = PH_MASK;
                            PH_VALUE: n_phase = PH_ATOM_LEN;
                            default:  n_phase = PH_RT_DEL;
                        endcase
                    end
                end
                PH_ROW_DEL, PH_RT_DEL: begin
                    // 4 bytes of deletion time, then 8 bytes of timestamp
                    if (r_fcnt < FCNT_W'(4)) n_dtime  = {r_dtime[23:0], b};
                    else                     n_tstamp = {r_tstamp[55:0], b};
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= FCNT_W'(12)) begin
                        n_fcnt     = '0;
                        n_phase    = PH_ATOM_LEN;
                        res_valid  = 1'b1;
                        res_kind   = (r_phase == PH_ROW_DEL) ? K_ROW_START : K_TOMBSTONE;
                        res_dtime  = n_dtime;
                        res_tstamp = n_tstamp;
                    end
                end
                PH_MASK: begin
                    n_fcnt = '0;
                    if (b[M_RANGE_TOMB]) begin
                        n_phase = PH_RT_LEN;
                    end else if (b[M_COUNTER]) begin
                        n_err     = E_COUNTER;
                        res_valid = 1'b1;
                        res_kind  = K_ERROR;
                        res_err   = E_COUNTER;
                    end else if (b[M_EXPIRATION]) begin
                        n_cell_del = 1'b0;
                        n_phase    = PH_EXP;
                    end else if (b[M_COUNTER_UPDATE]) begin
                        n_err     = E_COUNTER_UPD;
                        res_valid = 1'b1;
                        res_kind  = K_ERROR;
                        res_err   = E_COUNTER_UPD;
                    end else begin
                        n_ttl      = '0;
                        n_exp      = '0;
                        n_cell_del = b[M_DELETION];
                        n_phase    = PH_TS;
                    end
                end
                PH_EXP: begin
                    if (r_fcnt < FCNT_W'(4)) n_ttl = {r_ttl[23:0], b};
                    else                     n_exp = {r_exp[23:0], b};
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= FCNT_W'(8)) begin
                        n_fcnt  = '0;
                        n_phase = PH_TS;
                    end
                end
                PH_TS: begin
                    n_tstamp = {r_tstamp[55:0], b};
                    n_fcnt   = fcnt_inc;
                    if (fcnt_inc >= FCNT_W'(8)) begin
                        n_fcnt  = '0;
                        n_phase = PH_VLEN;
                    end
                end
                PH_VLEN: begin
                    n_len  = len_shift;
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= FCNT_W'(4)) begin
                        n_fcnt = '0;
                        if (r_cell_del) begin
                            if (len_shift != LEN_W'(4)) begin
                                n_fcnt    = fcnt_inc;
                                n_err     = E_DEL_SIZE;
                                res_valid = 1'b1;
                                res_kind  = K_ERROR;
                                res_err   = E_DEL_SIZE;
                            end else begin
                                n_phase = PH_DEL_VALUE;
                            end
                        end else begin
                            n_phase    = (len_shift == '0) ? PH_ATOM_LEN : PH_VALUE;
                            res_valid  = 1'b1;
                            res_kind   = K_CELL;
                            res_tstamp = r_tstamp;
                            res_ttl    = r_ttl;
                            res_exp    = r_exp;
                        end
                    end
                end
                PH_DEL_VALUE: begin
                    n_dtime = {r_dtime[23:0], b};
                    n_fcnt  = fcnt_inc;
                    if (fcnt_inc >= FCNT_W'(4)) begin
                        n_fcnt     = '0;
                        n_phase    = PH_ATOM_LEN;
                        res_valid  = 1'b1;
                        res_kind   = K_DEL_CELL;
                        res_dtime  = n_dtime;
                        res_tstamp = r_tstamp;
                    end
                end
                default: begin
                    n_phase = PH_ROW_LEN;
                    n_fcnt  = '0;
                end
            endcase
        end
    end

    // input register: fill when empty or when the parse stage drains it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
            r_in_end  <= s_tlast;
        end
    end

    // parser state: advance only on a consumed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ROW_LEN;
            r_fcnt     <= '0;
            r_len      <= '0;
            r_dtime    <= '0;
            r_tstamp   <= '0;
            r_ttl      <= '0;
            r_exp      <= '0;
            r_cell_del <= 1'b0;
            r_err      <= E_NONE;
        end else if (consume) begin
            r_phase    <= n_phase;
            r_fcnt     <= n_fcnt;
            r_len      <= n_len;
            r_dtime    <= n_dtime;
            r_tstamp   <= n_tstamp;
            r_ttl      <= n_ttl;
            r_exp      <= n_exp;
            r_cell_del <= n_cell_del;
            r_err      <= n_err;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume) begin
            r_out_valid <= res_valid;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (consume && res_valid) begin
            r_out_kind   <= res_kind;
            r_out_byte   <= res_byte;
            r_out_last   <= res_last;
            r_out_dtime  <= res_dtime;
            r_out_tstamp <= res_tstamp;
            r_out_ttl    <= res_ttl;
            r_out_exp    <= res_exp;
            r_out_err    <= res_err;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_kind;
    assign m_tlast  = r_out_last;
    assign m_tdata  = {{(OUT_TDATA_W-171){1'b0}}, r_out_err, r_out_exp, r_out_ttl,
                       r_out_tstamp, r_out_dtime, r_out_byte};

endmodule

`default_nettype wire
